[sv/kmpc_pkg.sv]
// Shared constants, operation and status codes for the pixel clustering block.
// No dependencies; every other file imports this package.
package kmpc_pkg;

  localparam int MAX_PIXELS   = 65536;
  localparam int MAX_CLUSTERS = 8;
  localparam int COMP_W       = 16;
  localparam int IDX_W        = $clog2(MAX_PIXELS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int LBL_W        = $clog2(MAX_CLUSTERS);
  localparam int K_W          = LBL_W + 1;
  localparam int SUM_W        = COMP_W + IDX_W + 1;
  localparam int DIST_W       = 2 * (COMP_W + 1) + 2;
  localparam int ITER_W       = 8;
  localparam int KREG_W       = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DAT_W    = 8;

  localparam logic [KREG_W-1:0] K_RESET    = KREG_W'(2);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(50);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LIMIT    = 2'd1;
  localparam logic [1:0] ST_TOO_FEW  = 2'd2;
  localparam logic [1:0] ST_BAD_IDX  = 2'd3;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = CFG_IDX_W'(1);

endpackage

[sv/kmpc_in_if.sv]
// Input channel of the clustering block: valid/ready plus one command word.
// Depends on kmpc_pkg.
interface kmpc_in_if import kmpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [COMP_W-1:0] comp_a;
  logic signed [COMP_W-1:0] comp_b;
  logic signed [COMP_W-1:0] comp_c;
  logic [IDX_W-1:0]         pixel_index;

  modport source (output valid, operation, comp_a, comp_b, comp_c, pixel_index,
                  input ready);
  modport sink   (input valid, operation, comp_a, comp_b, comp_c, pixel_index,
                  output ready);
endinterface

[sv/kmpc_out_if.sv]
// Result channel of the clustering block: valid/ready plus one result word.
// Depends on kmpc_pkg.
interface kmpc_out_if import kmpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [1:0]               status;
  logic [ITER_W-1:0]        passes_done;
  logic signed [COMP_W-1:0] center_a;
  logic signed [COMP_W-1:0] center_b;
  logic signed [COMP_W-1:0] center_c;
  logic [LBL_W-1:0]         cluster_label;

  modport source (output valid, result_kind, status, passes_done, center_a, center_b,
                  center_c, cluster_label, input ready);
  modport sink   (input valid, result_kind, status, passes_done, center_a, center_b,
                  center_c, cluster_label, output ready);
endinterface

[sv/kmpc_cfg_if.sv]
// Register write channel of the clustering block.
// Depends on kmpc_pkg.
interface kmpc_cfg_if import kmpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/kmeans_pixel_clustering.sv]
// Top level of the k-means pixel clustering block: pixel and label stores,
// sequencer, shared multiplier and divider. Depends on kmpc_pkg, the three
// channel interfaces and kmpc_divider.
//
// Use: in_ch carries commands (load, run, read, clear), out_ch carries one
// result word for each run and read, cfg_ch writes cluster_count (index 0)
// and max_iterations (index 1); cfg_ch is always ready.
// A load or clear is taken in S_IDLE and leaves the block ready for the next command.
// A read passes through label read and centroid select on its way to its result word.
// A run walks every pixel with one shared 17x17 multiplier: labelling forms the
// squared distance to each centroid one component at a time, and each refinement
// pass sums the pixels per cluster, divides each centroid component in the
// divider and then labels every pixel anew.
// in_ch is not ready while a run or read is in progress.
// Reset clears the centroids, sums, pixel count and registers (k=2, limit 50);
// the stores themselves are left as they are and need no clearing pass.
// A result waits in the output register while the receiver stalls; loads and
// clears are still taken meanwhile, a further run or read waits at its end.
module kmeans_pixel_clustering import kmpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  kmpc_in_if.sink    in_ch,
  kmpc_out_if.source out_ch,
  kmpc_cfg_if.sink   cfg_ch
);
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SEED_F, S_SEED_W, S_L_FETCH, S_L_MUL, S_L_ACC, S_L_WR,
    S_LOOP, S_A_FETCH, S_A_ADD, S_D_START, S_D_WAIT, S_RD_F, S_RD_D, S_OUT
  } state_t;

  typedef struct packed {
    logic                     kind;
    logic [1:0]               status;
    logic [ITER_W-1:0]        passes;
    logic signed [COMP_W-1:0] ca;
    logic signed [COMP_W-1:0] cb;
    logic signed [COMP_W-1:0] cc;
    logic [LBL_W-1:0]         lbl;
  } res_t;

  state_t state_r;
  logic [KREG_W-1:0] k_reg_r;
  logic [ITER_W-1:0] max_iter_r;
  logic [CNT_W-1:0]  elem_cnt_r, p_r;
  logic [IDX_W-1:0]  idx_r;
  logic [K_W-1:0]    k_r;
  logic [LBL_W-1:0]  clu_r, best_r;
  logic [1:0]        comp_r;
  logic              refine_r, changed_r;
  logic [ITER_W-1:0] pass_r;
  logic [DIST_W-1:0] sq_r, dacc_r, best_d_r;
  res_t              pend_r, res_r;
  logic              out_valid_r;

  logic signed [COMP_W-1:0] cen_r [MAX_CLUSTERS][3];
  logic signed [SUM_W-1:0]  sum_r [MAX_CLUSTERS][3];
  logic [CNT_W-1:0]         mcnt_r [MAX_CLUSTERS];

  logic [3*COMP_W-1:0] pix_mem [MAX_PIXELS];
  logic [LBL_W-1:0]    lbl_mem [MAX_PIXELS];
  logic [3*COMP_W-1:0] rd_pix_r;
  logic [LBL_W-1:0]    rd_lbl_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                pix_we, lbl_we;

  logic [LBL_W-1:0]           sel;
  logic signed [COMP_W-1:0]   pix_c;
  logic signed [COMP_W:0]     diff;
  logic signed [2*COMP_W+1:0] prod;
  logic [DIST_W-1:0]          dsum;
  logic [K_W-1:0]             k_eff;
  logic                       div_start, div_done;
  logic signed [SUM_W-1:0]    div_q;
  logic                       in_acc;

  assign in_acc = in_ch.valid & in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Single read address for centroids, sums and counts.
  assign sel = (state_r == S_RD_D || state_r == S_A_ADD) ? rd_lbl_r : clu_r;

  always_comb begin
    case (comp_r)
      2'd0:    pix_c = signed'(rd_pix_r[COMP_W-1:0]);
      2'd1:    pix_c = signed'(rd_pix_r[2*COMP_W-1:COMP_W]);
      default: pix_c = signed'(rd_pix_r[3*COMP_W-1:2*COMP_W]);
    endcase
  end

  assign diff = {pix_c[COMP_W-1], pix_c} - {cen_r[sel][comp_r][COMP_W-1], cen_r[sel][comp_r]};
  assign prod = diff * diff;
  assign dsum = dacc_r + sq_r;

  always_comb begin
    if (k_reg_r == '0) k_eff = K_W'(1);
    else if (k_reg_r > KREG_W'(MAX_CLUSTERS)) k_eff = K_W'(MAX_CLUSTERS);
    else k_eff = K_W'(k_reg_r);
  end

  assign rd_addr   = (state_r == S_RD_F) ? idx_r : p_r[IDX_W-1:0];
  assign pix_we    = in_acc && in_ch.operation == OP_LOAD && elem_cnt_r < CNT_W'(MAX_PIXELS);
  assign lbl_we    = (state_r == S_L_WR);
  assign div_start = (state_r == S_D_START) && mcnt_r[sel] != '0;

  always_ff @(posedge clk) begin
    if (pix_we)
      pix_mem[elem_cnt_r[IDX_W-1:0]] <= {in_ch.comp_c, in_ch.comp_b, in_ch.comp_a};
    if (lbl_we)
      lbl_mem[p_r[IDX_W-1:0]] <= best_r;
    rd_pix_r <= pix_mem[rd_addr];
    rd_lbl_r <= lbl_mem[rd_addr];
  end

  kmpc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[sel][comp_r]),
    .divisor  (mcnt_r[sel]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_reg_r    <= K_RESET;
      max_iter_r <= ITER_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_CLUSTER_COUNT)
        k_reg_r <= cfg_ch.data[KREG_W-1:0];
      else if (cfg_ch.index == REG_MAX_ITERATIONS)
        max_iter_r <= cfg_ch.data[ITER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
      pass_r      <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        mcnt_r[i] <= '0;
        for (int c = 0; c < 3; c++) begin
          cen_r[i][c] <= '0;
          sum_r[i][c] <= '0;
        end
      end
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready))
        out_valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready)
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.operation)
              OP_LOAD: if (pix_we) elem_cnt_r <= elem_cnt_r + CNT_W'(1);
              OP_CLEAR: elem_cnt_r <= '0;
              OP_RUN: begin
                pend_r  <= '0;
                state_r <= S_CHECK;
              end
              default: begin
                idx_r <= in_ch.pixel_index;
                if (CNT_W'(in_ch.pixel_index) >= elem_cnt_r) begin
                  pend_r  <= '{kind: KIND_READ, status: ST_BAD_IDX, default: '0};
                  state_r <= S_OUT;
                end else begin
                  pend_r  <= '{kind: KIND_READ, status: ST_OK, default: '0};
                  state_r <= S_RD_F;
                end
              end
            endcase
          end
        end
        S_CHECK: begin
          k_r <= k_eff;
          if (elem_cnt_r < CNT_W'(k_eff)) begin
            pend_r.status <= ST_TOO_FEW;
            state_r       <= S_OUT;
          end else begin
            p_r     <= '0;
            state_r <= S_SEED_F;
          end
        end
        S_SEED_F: state_r <= S_SEED_W;
        S_SEED_W: begin
          cen_r[p_r[LBL_W-1:0]][0] <= signed'(rd_pix_r[COMP_W-1:0]);
          cen_r[p_r[LBL_W-1:0]][1] <= signed'(rd_pix_r[2*COMP_W-1:COMP_W]);
          cen_r[p_r[LBL_W-1:0]][2] <= signed'(rd_pix_r[3*COMP_W-1:2*COMP_W]);
          if (p_r + CNT_W'(1) == CNT_W'(k_r)) begin
            p_r      <= '0;
            refine_r <= 1'b0;
            pass_r   <= '0;
            state_r  <= S_L_FETCH;
          end else begin
            p_r     <= p_r + CNT_W'(1);
            state_r <= S_SEED_F;
          end
        end
        S_L_FETCH: begin
          clu_r   <= '0;
          comp_r  <= '0;
          dacc_r  <= '0;
          state_r <= S_L_MUL;
        end
        S_L_MUL: begin
          sq_r    <= DIST_W'(unsigned'(prod));
          state_r <= S_L_ACC;
        end
        S_L_ACC: begin
          state_r <= S_L_MUL;
          if (comp_r == 2'd2) begin
            if (clu_r == '0 || dsum < best_d_r) begin
              best_d_r <= dsum;
              best_r   <= clu_r;
            end
            dacc_r <= '0;
            comp_r <= '0;
            if (K_W'(clu_r) + K_W'(1) == k_r) state_r <= S_L_WR;
            else clu_r <= clu_r + LBL_W'(1);
          end else begin
            dacc_r <= dsum;
            comp_r <= comp_r + 2'd1;
          end
        end
        S_L_WR: begin
          if (refine_r && best_r != rd_lbl_r) changed_r <= 1'b1;
          if (p_r + CNT_W'(1) == elem_cnt_r) begin
            if (!refine_r) changed_r <= 1'b1;
            state_r <= S_LOOP;
          end else begin
            p_r     <= p_r + CNT_W'(1);
            state_r <= S_L_FETCH;
          end
        end
        S_LOOP: begin
          if (pass_r < max_iter_r && changed_r) begin
            pass_r <= pass_r + ITER_W'(1);
            p_r    <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              mcnt_r[i] <= '0;
              for (int c = 0; c < 3; c++) sum_r[i][c] <= '0;
            end
            state_r <= S_A_FETCH;
          end else begin
            pend_r.status <= changed_r ? ST_LIMIT : ST_OK;
            pend_r.passes <= pass_r;
            state_r       <= S_OUT;
          end
        end
        S_A_FETCH: state_r <= S_A_ADD;
        S_A_ADD: begin
          sum_r[sel][0] <= sum_r[sel][0] + SUM_W'(signed'(rd_pix_r[COMP_W-1:0]));
          sum_r[sel][1] <= sum_r[sel][1] + SUM_W'(signed'(rd_pix_r[2*COMP_W-1:COMP_W]));
          sum_r[sel][2] <= sum_r[sel][2] + SUM_W'(signed'(rd_pix_r[3*COMP_W-1:2*COMP_W]));
          mcnt_r[sel]   <= mcnt_r[sel] + CNT_W'(1);
          if (p_r + CNT_W'(1) == elem_cnt_r) begin
            clu_r   <= '0;
            comp_r  <= '0;
            state_r <= S_D_START;
          end else begin
            p_r     <= p_r + CNT_W'(1);
            state_r <= S_A_FETCH;
          end
        end
        S_D_START: begin
          if (mcnt_r[sel] == '0) cen_r[sel][comp_r] <= '0;
          state_r <= S_D_WAIT;
        end
        S_D_WAIT: begin
          if (div_done || mcnt_r[sel] == '0) begin
            if (div_done) cen_r[sel][comp_r] <= div_q[COMP_W-1:0];
            state_r <= S_D_START;
            if (comp_r == 2'd2) begin
              comp_r <= '0;
              if (K_W'(clu_r) + K_W'(1) == k_r) begin
                p_r       <= '0;
                refine_r  <= 1'b1;
                changed_r <= 1'b0;
                state_r   <= S_L_FETCH;
              end else begin
                clu_r <= clu_r + LBL_W'(1);
              end
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        S_RD_F: state_r <= S_RD_D;
        S_RD_D: begin
          pend_r.ca  <= cen_r[sel][0];
          pend_r.cb  <= cen_r[sel][1];
          pend_r.cc  <= cen_r[sel][2];
          pend_r.lbl <= rd_lbl_r;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            res_r   <= pend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = res_r.kind;
  assign out_ch.status        = res_r.status;
  assign out_ch.passes_done   = res_r.passes;
  assign out_ch.center_a      = res_r.ca;
  assign out_ch.center_b      = res_r.cb;
  assign out_ch.center_c      = res_r.cc;
  assign out_ch.cluster_label = res_r.lbl;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elem_cnt_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count above store depth");
  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_L_WR |-> K_W'(best_r) < k_r)
    else $error("label outside cluster range");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_D_WAIT)
    else $error("divider result while not waiting");
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOP |-> pass_r <= max_iter_r)
    else $error("pass count past limit");
endmodule

[sv/kmpc_divider.sv]
// Restoring divider: signed sum over unsigned count, truncated toward zero.
// One quotient bit per cycle. Depends on kmpc_pkg.
module kmpc_divider import kmpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[CNT_W-1:0], q_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= dividend[SUM_W-1];
        q_r    <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
        q_r    <= {q_r[SUM_W-2:0], ge};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(q_r) : signed'(q_r);
endmodule

[dv/tb_top.sv]
// Self-checking testbench for kmeans_pixel_clustering: directed and random
// load/run/read/clear traffic checked against an in-bench clustering predictor.
// Depends on kmpc_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import kmpc_pkg::*;

  typedef struct {
    logic                     kind;
    logic [1:0]               status;
    logic [ITER_W-1:0]        passes;
    logic signed [COMP_W-1:0] ca;
    logic signed [COMP_W-1:0] cb;
    logic signed [COMP_W-1:0] cc;
    logic [LBL_W-1:0]         label;
  } result_t;

  logic clk;
  logic rst_n;

  kmpc_in_if  in_ch ();
  kmpc_out_if out_ch ();
  kmpc_cfg_if cfg_ch ();

  kmeans_pixel_clustering dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  int          pix [MAX_PIXELS][3];
  int          lbl [MAX_PIXELS];
  bit          lbl_written [MAX_PIXELS];
  longint      centers [MAX_CLUSTERS][3];
  int          pix_count;
  logic [KREG_W-1:0] k_reg;
  logic [ITER_W-1:0] iter_reg;

  result_t     pending_results [$];
  int          errors = 0;
  int          burst_left;
  int          words_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2s;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int nearest_center(int p, int k);
    int     best;
    longint bestd;
    longint d;
    longint t;
    best  = 0;
    bestd = 0;
    for (int i = 0; i < k; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        t = longint'(pix[p][c]) - centers[i][c];
        d += t * t;
      end
      if (i == 0 || d < bestd) begin
        bestd = d;
        best  = i;
      end
    end
    return best;
  endfunction

  function automatic result_t cluster_run();
    result_t r;
    int      k;
    int      passes;
    bit      changed;
    int      l;
    longint  sums [MAX_CLUSTERS][3];
    int      members [MAX_CLUSTERS];
    r = '{KIND_RUN, ST_OK, '0, '0, '0, '0, '0};
    k = (k_reg == 0) ? 1 : (k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(k_reg);
    if (pix_count < k) begin
      r.status = ST_TOO_FEW;
      return r;
    end
    for (int i = 0; i < k; i++)
      for (int c = 0; c < 3; c++) centers[i][c] = pix[i][c];
    for (int p = 0; p < pix_count; p++) begin
      lbl[p] = nearest_center(p, k);
      lbl_written[p] = 1'b1;
    end
    changed = 1'b1;
    passes  = 0;
    while (passes < iter_reg && changed) begin
      passes++;
      for (int i = 0; i < k; i++) begin
        members[i] = 0;
        for (int c = 0; c < 3; c++) sums[i][c] = 0;
      end
      for (int p = 0; p < pix_count; p++) begin
        l = lbl[p] % k;
        members[l]++;
        for (int c = 0; c < 3; c++) sums[l][c] += pix[p][c];
      end
      // truncating divide; empty cluster collapses to the origin
      for (int i = 0; i < k; i++)
        for (int c = 0; c < 3; c++)
          centers[i][c] = (members[i] == 0) ? 0 : sums[i][c] / members[i];
      changed = 1'b0;
      for (int p = 0; p < pix_count; p++) begin
        l = nearest_center(p, k);
        if (l != lbl[p]) changed = 1'b1;
        lbl[p] = l;
      end
    end
    r.status = changed ? ST_LIMIT : ST_OK;
    r.passes = ITER_W'(passes);
    return r;
  endfunction

  function automatic void predict_word(op_t op, logic [15:0] a, logic [15:0] b,
                                       logic [15:0] c, logic [IDX_W-1:0] idx);
    result_t r;
    int      l;
    case (op)
      OP_LOAD: begin
        if (pix_count < MAX_PIXELS) begin
          pix[pix_count][0] = int'($signed(a));
          pix[pix_count][1] = int'($signed(b));
          pix[pix_count][2] = int'($signed(c));
          pix_count++;
        end
      end
      OP_CLEAR: pix_count = 0;
      OP_RUN: pending_results = {pending_results, cluster_run()};
      default: begin
        r = '{KIND_READ, ST_OK, '0, '0, '0, '0, '0};
        if (int'(idx) >= pix_count) begin
          r.status = ST_BAD_IDX;
        end else begin
          l = lbl[idx] % MAX_CLUSTERS;
          r.ca    = COMP_W'(centers[l][0]);
          r.cb    = COMP_W'(centers[l][1]);
          r.cc    = COMP_W'(centers[l][2]);
          r.label = LBL_W'(l);
        end
        pending_results = {pending_results, r};
      end
    endcase
  endfunction

  task automatic send_word(op_t op, logic [15:0] a = '0, logic [15:0] b = '0,
                           logic [15:0] c = '0, logic [IDX_W-1:0] idx = '0);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.comp_a      <= a;
    in_ch.comp_b      <= b;
    in_ch.comp_c      <= c;
    in_ch.pixel_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(op, a, b, c, idx);
    words_sent++;
  endtask

  // sender holds off until every expected word is back and the block is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == REG_CLUSTER_COUNT) k_reg = data[KREG_W-1:0];
    else if (index == REG_MAX_ITERATIONS) iter_reg = data;
  endtask

  task automatic set_regs(logic [CFG_DAT_W-1:0] k, logic [CFG_DAT_W-1:0] iters);
    settle();
    write_reg(REG_CLUSTER_COUNT, k);
    write_reg(REG_MAX_ITERATIONS, iters);
  endtask

  // component near one of a few hot spots, or anywhere in range
  function automatic logic [15:0] rand_comp(int spot);
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'(spot * 9000 - 13000 + $urandom_range(0, 1200));
  endfunction

  task automatic load_pixel();
    int spot;
    spot = $urandom_range(0, 3);
    send_word(OP_LOAD, rand_comp(spot), rand_comp(spot), rand_comp(spot));
  endtask

  // in range only where a run has written the label, else out of range
  task automatic read_some();
    int idx;
    idx = (pix_count > 0) ? $urandom_range(0, pix_count - 1) : 0;
    if (pix_count == 0 || !lbl_written[idx] || $urandom_range(0, 5) == 0)
      idx = $urandom_range(pix_count, MAX_PIXELS - 1);
    send_word(OP_READ, '0, '0, '0, IDX_W'(idx));
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // receiver: checks each result word and changes its stall mode periodically
  int stall_mode = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result word with nothing expected", $realtime);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_ch.result_kind !== w.kind) report_mismatch("result_kind", out_ch.result_kind, w.kind);
        if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
        if (out_ch.passes_done !== w.passes) report_mismatch("passes_done", out_ch.passes_done, w.passes);
        if (out_ch.center_a !== w.ca) report_mismatch("center_a", out_ch.center_a, w.ca);
        if (out_ch.center_b !== w.cb) report_mismatch("center_b", out_ch.center_b, w.cb);
        if (out_ch.center_c !== w.cc) report_mismatch("center_c", out_ch.center_c, w.cc);
        if (out_ch.cluster_label !== w.label) report_mismatch("cluster_label", out_ch.cluster_label, w.label);
      end
    end
    stall_phase++;
    if (stall_phase % 48 == 0) stall_mode = $urandom_range(0, 3);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= stall_phase[1];
      endcase
    end
  end

  task automatic test_basic_ops();
    send_word(OP_RUN);                                  // empty store: too few
    send_word(OP_READ, '0, '0, '0, '0);
    send_word(OP_READ, '0, '0, '0, '1);
    send_word(OP_LOAD, 16'h7FFF, 16'h8000, 16'h0000);
    send_word(OP_LOAD, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_word(OP_LOAD, 16'h0001, 16'h0002, 16'h0003);
    send_word(OP_LOAD, 16'h7FFF, 16'h8000, 16'h0000);   // duplicate: tie
    send_word(OP_RUN);
    for (int i = 0; i < 5; i++) send_word(OP_READ, '0, '0, '0, IDX_W'(i));
    send_word(OP_LOAD, 16'h5555, 16'hAAAA, 16'h0F0F);
    send_word(OP_CLEAR);
    send_word(OP_READ, '0, '0, '0, '0);
  endtask

  task automatic test_register_extremes();
    logic [7:0] settings [6][2] = '{'{8'd0, 8'd0}, '{8'd1, 8'd1}, '{8'd8, 8'd255},
                                    '{8'd15, 8'd2}, '{8'd3, 8'd1}, '{8'd2, 8'd50}};
    for (int s = 0; s < 6; s++) begin
      set_regs(settings[s][0], settings[s][1]);
      send_word(OP_CLEAR);
      repeat (10) load_pixel();
      send_word(OP_RUN);
      repeat (4) read_some();
    end
    // k above the cluster limit with fewer pixels than the limit
    set_regs(8'd15, 8'd3);
    send_word(OP_CLEAR);
    repeat (5) load_pixel();
    send_word(OP_RUN);
  endtask

  task automatic test_random_traffic();
    int start;
    int n;
    int k;
    start = words_sent;
    while (words_sent - start < 1480) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: set_regs(8'($urandom_range(0, 15)), 8'd0);
          1: set_regs(8'($urandom_range(0, 15)), 8'd255);
          default: set_regs(8'($urandom_range(0, 15)), 8'($urandom_range(1, 10)));
        endcase
      end else begin
        settle();
      end
      k = (k_reg == 0) ? 1 : (k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(k_reg);
      if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, k) : $urandom_range(k, 20);
      for (int i = 0; i < n; i++) begin
        load_pixel();
        if ($urandom_range(0, 9) == 0) read_some();
      end
      send_word(OP_RUN);
      repeat ($urandom_range(2, 12)) read_some();
      if ($urandom_range(0, 4) == 0) send_word(OP_LOAD, 16'($urandom), 16'($urandom),
                                               16'($urandom));
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.comp_a      = '0;
    in_ch.comp_b      = '0;
    in_ch.comp_c      = '0;
    in_ch.pixel_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_CLUSTER_COUNT;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    burst_left        = 0;
    words_sent        = 0;
    pix_count         = 0;
    k_reg             = K_RESET;
    iter_reg          = ITER_RESET;
    for (int i = 0; i < MAX_CLUSTERS; i++)
      for (int c = 0; c < 3; c++) centers[i][c] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_register_extremes();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
